FILE: src/gve_pkg.sv
package gve_pkg;

    // fixed widths of the datapath
    localparam int XY_W = 36;
    localparam int Z_W = 32;
    localparam int ATAN_LEN = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    // register indexes
    typedef enum logic [1:0] {
        REG_SAMPLE_RATE = 2'd0,
        REG_SPEED_LIMIT = 2'd1,
        REG_YAW_DRIFT = 2'd2,
        REG_NEGATE_RATE = 2'd3
    } reg_index_t;

    // register reset values
    localparam logic [9:0] RATE_RST = 10'd10;
    localparam logic [15:0] LIMIT_RST = 16'd200;
    localparam logic signed [8:0] DRIFT_RST = 9'sd0;
    localparam logic NEGATE_RST = 1'b1;

    // angle and scale constants
    localparam logic signed [16:0] HALF_TURN = 17'sd11520;
    localparam logic signed [16:0] FULL_TURN = 17'sd23040;
    localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;
    localparam logic signed [18:0] HEAD_SCALE = 19'sd146409;
    localparam logic signed [17:0] RAD_Q28_PER_UNIT = 18'sd73204;
    localparam logic signed [16:0] GAIN_Q16 = 17'sd39797;
    localparam logic signed [15:0] RATE_SCALE = 16'sd17872;

    // handshake between cells
    typedef struct packed {
        logic valid;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0] z;
    } cordic_beat_t;

    // arctangent of 2^-i in radians, 28 fraction bits
    function automatic logic signed [Z_W-1:0] atan_q28(input int i);
        logic signed [Z_W-1:0] a;
        case (i)
            0: a = 32'sd210828714;
            1: a = 32'sd124459457;
            2: a = 32'sd65760959;
            3: a = 32'sd33381289;
            4: a = 32'sd16755422;
            5: a = 32'sd8385879;
            6: a = 32'sd4193963;
            7: a = 32'sd2097109;
            8: a = 32'sd1048571;
            9: a = 32'sd524287;
            default: a = Z_W'(32'sd262144 >>> (i - 10));
        endcase
        return a;
    endfunction

endpackage

FILE: src/gps_imu_body_velocity_estimator_core.sv
// channel | direction | handshake          | payload
// input   | in        | in_valid/in_stall  | in_x_mm in_y_mm yaw_deg64 yaw_rate_deg64
// output  | out       | out_valid/out_stall| out_x_mm out_y_mm heading_q13 surge/sway
//         |           |                    | yaw_rate_mrad_s
// config  | in        | cfg_valid/cfg_ready| cfg_index cfg_data
//
// one beat at a time: the beat passes stage a, stage b, the row of CORDIC cells (one
// rotation per cell), the gain register and the output register
// in_stall stays high from accept until the result beat is taken
// reset clears the previous position and first-sample flag and resets the registers
// config writes are always ready
module gps_imu_body_velocity_estimator_core #(
    parameter int CORDIC_STEPS = gve_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] in_x_mm,
    input  logic signed [23:0] in_y_mm,
    input  logic [14:0]        yaw_deg64,
    input  logic signed [17:0] yaw_rate_deg64,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] out_x_mm,
    output logic signed [23:0] out_y_mm,
    output logic signed [15:0] heading_q13,
    output logic signed [17:0] surge_mm_s,
    output logic signed [17:0] sway_mm_s,
    output logic signed [16:0] yaw_rate_mrad_s,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import gve_pkg::*;

    localparam int N = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

    // configuration registers
    logic [9:0] rate_hz_reg;
    logic [15:0] limit_reg;
    logic signed [8:0] drift_reg;
    logic negate_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_hz_reg <= RATE_RST;
            limit_reg <= LIMIT_RST;
            drift_reg <= DRIFT_RST;
            negate_reg <= NEGATE_RST;
        end
        else if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_SAMPLE_RATE: rate_hz_reg <= cfg_data[9:0];
                REG_SPEED_LIMIT: limit_reg <= cfg_data;
                REG_YAW_DRIFT: drift_reg <= cfg_data[8:0];
                REG_NEGATE_RATE: negate_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // control
    logic busy_reg, a_v_reg, b_v_reg, g_v_reg, out_v_reg;
    logic in_acc, out_acc;
    cordic_beat_t chain [0:N];

    assign in_acc = in_valid && !busy_reg;
    assign out_acc = out_v_reg && !out_stall;
    assign in_stall = busy_reg;
    assign out_valid = out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= in_acc;
            b_v_reg <= a_v_reg;
            g_v_reg <= chain[N].valid;
            if (in_acc)
                busy_reg <= 1'b1;
            else if (out_acc)
                busy_reg <= 1'b0;
            if (g_v_reg)
                out_v_reg <= 1'b1;
            else if (out_acc)
                out_v_reg <= 1'b0;
        end
    end

    // previous position and first-sample flag
    logic signed [23:0] prev_x_reg, prev_y_reg;
    logic seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            seen_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            prev_x_reg <= in_x_mm;
            prev_y_reg <= in_y_mm;
            seen_reg <= 1'b1;
        end
    end

    // stage a: capture beat and position difference
    logic signed [23:0] px_reg, py_reg;
    logic [14:0] yaw_reg;
    logic signed [17:0] yrate_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic first_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            px_reg <= in_x_mm;
            py_reg <= in_y_mm;
            yaw_reg <= yaw_deg64;
            yrate_reg <= yaw_rate_deg64;
            dx_reg <= 25'(in_x_mm) - 25'(prev_x_reg);
            dy_reg <= 25'(in_y_mm) - 25'(prev_y_reg);
            first_reg <= !seen_reg;
        end
    end

    // stage b: velocity products, drift removal and single wrap
    logic signed [34:0] vxp_reg, vyp_reg;
    logic signed [16:0] d_reg, d_next;
    logic signed [32:0] yrp_reg;
    logic signed [10:0] rate_s;

    assign rate_s = $signed({1'b0, rate_hz_reg});

    always_comb
    begin
        d_next = $signed({2'b00, yaw_reg}) - (17'(drift_reg) <<< 6);
        if (d_next < -HALF_TURN)
            d_next = d_next + FULL_TURN;
        if (d_next > HALF_TURN)
            d_next = d_next - FULL_TURN;
    end

    always_ff @(posedge clk)
    begin
        if (a_v_reg)
        begin
            vxp_reg <= 35'(dx_reg * rate_s);
            vyp_reg <= 35'(dy_reg * rate_s);
            d_reg <= d_next;
            yrp_reg <= 33'(yrate_reg * RATE_SCALE);
        end
    end

    // stage c: saturation, quadrant fold, angle, heading, yaw rate
    logic signed [16:0] lim_s;
    logic signed [16:0] vx_s, vy_s;
    logic signed [16:0] e1, e2;
    logic fold;
    logic signed [XY_W-1:0] x0, y0;
    logic signed [Z_W-1:0] z0;
    logic signed [35:0] head_p;
    logic signed [19:0] head_r;
    logic signed [15:0] head_s;
    logic signed [16:0] yr_r;
    logic signed [15:0] head_reg;
    logic signed [16:0] yr_reg;

    assign lim_s = $signed({1'b0, limit_reg});

    always_comb
    begin
        // velocity clamp, zero on the first sample
        if (vxp_reg > 35'(lim_s))
            vx_s = lim_s;
        else if (vxp_reg < -35'(lim_s))
            vx_s = -lim_s;
        else
            vx_s = vxp_reg[16:0];
        if (vyp_reg > 35'(lim_s))
            vy_s = lim_s;
        else if (vyp_reg < -35'(lim_s))
            vy_s = -lim_s;
        else
            vy_s = vyp_reg[16:0];
        if (first_reg)
        begin
            vx_s = '0;
            vy_s = '0;
        end
        // reduce to a half turn either side, minus half turn maps to plus
        if (d_reg > HALF_TURN)
            e1 = d_reg - FULL_TURN;
        else if (d_reg == -HALF_TURN)
            e1 = HALF_TURN;
        else
            e1 = d_reg;
        fold = 1'b0;
        e2 = e1;
        if (e1 > QUARTER_TURN)
        begin
            fold = 1'b1;
            e2 = e1 - HALF_TURN;
        end
        else if (e1 < -QUARTER_TURN)
        begin
            fold = 1'b1;
            e2 = e1 + HALF_TURN;
        end
        x0 = XY_W'(vx_s) <<< 16;
        y0 = XY_W'(vy_s) <<< 16;
        if (fold)
        begin
            x0 = -x0;
            y0 = -y0;
        end
        z0 = -Z_W'(e2 * RAD_Q28_PER_UNIT);
        // heading with rounding and saturation
        head_p = 36'(d_reg * HEAD_SCALE) + 36'sd32768;
        head_r = head_p[35:16];
        if (head_r > 20'sd32767)
            head_s = 16'sh7FFF;
        else if (head_r < -20'sd32768)
            head_s = 16'sh8000;
        else
            head_s = head_r[15:0];
        // yaw rate rounding and sign
        yr_r = 17'((yrp_reg + 33'sd32768) >>> 16);
        if (negate_reg)
            yr_r = -yr_r;
    end

    always_ff @(posedge clk)
    begin
        if (b_v_reg)
        begin
            head_reg <= head_s;
            yr_reg <= yr_r;
        end
    end

    // row of rotation cells
    assign chain[0].valid = b_v_reg;
    assign chain[0].x = x0;
    assign chain[0].y = y0;
    assign chain[0].z = z0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        gve_cordic_cell #(
            .STEP(i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .beat_in (chain[i]),
            .beat_out(chain[i+1])
        );
    end

    // gain correction
    logic signed [52:0] gx_reg, gy_reg;

    always_ff @(posedge clk)
    begin
        if (chain[N].valid)
        begin
            gx_reg <= 53'(chain[N].x * GAIN_Q16);
            gy_reg <= 53'(chain[N].y * GAIN_Q16);
        end
    end

    // round, saturate and present the result beat
    logic signed [20:0] sx_r, sy_r;
    logic signed [17:0] sx_s, sy_s;

    always_comb
    begin
        sx_r = 21'((gx_reg + 53'sd2147483648) >>> 32);
        sy_r = 21'((gy_reg + 53'sd2147483648) >>> 32);
        if (sx_r > 21'sd131071)
            sx_s = 18'sh1FFFF;
        else if (sx_r < -21'sd131072)
            sx_s = 18'sh20000;
        else
            sx_s = sx_r[17:0];
        if (sy_r > 21'sd131071)
            sy_s = 18'sh1FFFF;
        else if (sy_r < -21'sd131072)
            sy_s = 18'sh20000;
        else
            sy_s = sy_r[17:0];
    end

    always_ff @(posedge clk)
    begin
        if (g_v_reg)
        begin
            out_x_mm <= px_reg;
            out_y_mm <= py_reg;
            heading_q13 <= head_reg;
            surge_mm_s <= sx_s;
            sway_mm_s <= sy_s;
            yaw_rate_mrad_s <= yr_reg;
        end
    end

endmodule

FILE: src/gve_cordic_cell.sv
module gve_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gve_pkg::cordic_beat_t beat_in,
    output gve_pkg::cordic_beat_t beat_out
);
    import gve_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = atan_q28(STEP);

    logic valid_reg;
    logic signed [XY_W-1:0] x_reg, x_next;
    logic signed [XY_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0] z_reg, z_next;

    // one rotation step, direction from the residual angle
    always_comb
    begin
        if (!beat_in.z[Z_W-1])
        begin
            x_next = beat_in.x - (beat_in.y >>> STEP);
            y_next = beat_in.y + (beat_in.x >>> STEP);
            z_next = beat_in.z - ATAN;
        end
        else
        begin
            x_next = beat_in.x + (beat_in.y >>> STEP);
            y_next = beat_in.y - (beat_in.x >>> STEP);
            z_next = beat_in.z + ATAN;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= beat_in.valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (beat_in.valid)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign beat_out.valid = valid_reg;
    assign beat_out.x = x_reg;
    assign beat_out.y = y_reg;
    assign beat_out.z = z_reg;

endmodule

FILE: bench/tb_gps_imu_body_velocity_estimator_core.sv
`timescale 1ns / 100ps

module tb_gps_imu_body_velocity_estimator_core;
    import gve_pkg::*;

    typedef struct {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [15:0] head;
        logic signed [17:0] surge;
        logic signed [17:0] sway;
        logic signed [16:0] yr;
    } nav_result_t;

    class nav_scoreboard;
        // register copies and sample history
        logic [9:0]  rate_hz;
        logic [15:0] limit;
        logic signed [8:0] drift;
        logic        negate;
        longint      last_x;
        longint      last_y;
        bit          have_first;
        nav_result_t pending[$];
        int          errors;

        function new();
            rate_hz = RATE_RST;
            limit = LIMIT_RST;
            drift = DRIFT_RST;
            negate = NEGATE_RST;
            last_x = 0;
            last_y = 0;
            have_first = 0;
            errors = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [15:0] data);
            case (idx)
                REG_SAMPLE_RATE: rate_hz = data[9:0];
                REG_SPEED_LIMIT: limit = data;
                REG_YAW_DRIFT:   drift = data[8:0];
                REG_NEGATE_RATE: negate = data[0];
                default: ;
            endcase
        endfunction

        static function longint floor_sh(longint v, int s);
            return v >>> s;
        endfunction

        static function longint clamp(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim - 1) return -lim - 1;
            return v;
        endfunction

        static function longint atan_entry(int i);
            longint tbl[24] = '{210828714, 124459457, 65760959, 33381289, 16755422,
                8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072,
                65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
            return tbl[i];
        endfunction

        // work out the result beat that one input beat will cause
        function void note_input(logic signed [23:0] ix, logic signed [23:0] iy,
                                 logic [14:0] yaw, logic signed [17:0] rate);
            longint vx, vy, d, e, x, y, z, dx, dy, r, lim;
            int steps;
            nav_result_t res;
            steps = (CORDIC_STEPS_DEF > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS_DEF;
            lim = limit;
            vx = (longint'(ix) - last_x) * longint'(rate_hz);
            vy = (longint'(iy) - last_y) * longint'(rate_hz);
            if (vx > lim) vx = lim;
            if (vx < -lim) vx = -lim;
            if (vy > lim) vy = lim;
            if (vy < -lim) vy = -lim;
            if (!have_first)
            begin
                vx = 0;
                vy = 0;
                have_first = 1;
            end
            d = longint'(yaw) - 64 * longint'(drift);
            if (d < -11520) d += 23040;
            if (d > 11520) d -= 23040;
            res.head = 16'(clamp(floor_sh(d * 146409 + 32768, 16), 32767));
            e = ((d % 23040) + 23040) % 23040;
            if (e > 11520) e -= 23040;
            x = vx * 65536;
            y = vy * 65536;
            if (e > 5760)
            begin
                x = -x; y = -y; e -= 11520;
            end
            else if (e < -5760)
            begin
                x = -x; y = -y; e += 11520;
            end
            z = -(e * 73204);
            for (int i = 0; i < steps; i++)
            begin
                dx = floor_sh(y, i);
                dy = floor_sh(x, i);
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= atan_entry(i);
                end
                else
                begin
                    x += dx; y -= dy; z += atan_entry(i);
                end
            end
            res.surge = 18'(clamp(floor_sh(x * 39797 + (longint'(1) << 31), 32), 131071));
            res.sway = 18'(clamp(floor_sh(y * 39797 + (longint'(1) << 31), 32), 131071));
            r = floor_sh(longint'(rate) * 17872 + 32768, 16);
            if (negate) r = -r;
            res.yr = 17'(r);
            res.px = ix;
            res.py = iy;
            last_x = ix;
            last_y = iy;
            pending.push_back(res);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(nav_result_t got);
            nav_result_t w;
            if (pending.size() == 0)
            begin
                report("unexpected beat", 0, 0);
                return;
            end
            w = pending.pop_front();
            if (got.px !== w.px) report("out_x_mm", got.px, w.px);
            if (got.py !== w.py) report("out_y_mm", got.py, w.py);
            if (got.head !== w.head) report("heading_q13", got.head, w.head);
            if (got.surge !== w.surge) report("surge_mm_s", got.surge, w.surge);
            if (got.sway !== w.sway) report("sway_mm_s", got.sway, w.sway);
            if (got.yr !== w.yr) report("yaw_rate_mrad_s", got.yr, w.yr);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [23:0] in_x_mm = 0;
    logic signed [23:0] in_y_mm = 0;
    logic [14:0] yaw_deg64 = 0;
    logic signed [17:0] yaw_rate_deg64 = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [23:0] out_x_mm, out_y_mm;
    logic signed [15:0] heading_q13;
    logic signed [17:0] surge_mm_s, sway_mm_s;
    logic signed [16:0] yaw_rate_mrad_s;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [1:0] cfg_index = 0;
    logic [15:0] cfg_data = 0;

    nav_scoreboard board;
    int idle_cycles;
    int stall_left;
    longint pos_x, pos_y;

    localparam int WATCHDOG_LIMIT = 4000;

    gps_imu_body_velocity_estimator_core uut (.*);

    always #6 clk = ~clk;

    // result side: random stalls, check every accepted beat
    always @(posedge clk)
    begin
        nav_result_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.px = out_x_mm; got.py = out_y_mm; got.head = heading_q13;
                got.surge = surge_mm_s; got.sway = sway_mm_s;
                got.yr = yaw_rate_mrad_s;
                board.check_result(got);
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1;
            end
            else
            begin
                stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                out_stall <= 0;
            end
        end
    end

    // watchdog on cycles with no beat at all
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one register write, with cfg_valid dropped again before the task returns
    task write_cfg(reg_index_t idx, logic [15:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, data);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // valid stays up after the beat until the next gap or the drain
    task send_nav(logic signed [23:0] x, logic signed [23:0] y,
                  logic [14:0] yaw, logic signed [17:0] rate);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        in_x_mm <= x;
        in_y_mm <= y;
        yaw_deg64 <= yaw;
        yaw_rate_deg64 <= rate;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_input(x, y, yaw, rate);
    endtask

    task drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task random_phase(int count);
        logic [14:0] yaw;
        for (int i = 0; i < count; i++)
        begin
            // mostly small moves, with an occasional jump to a random position
            if ($urandom_range(0, 9) == 0)
            begin
                pos_x = $signed(24'($urandom));
                pos_y = $signed(24'($urandom));
            end
            else
            begin
                pos_x = $signed(24'(pos_x + $signed($urandom_range(0, 400)) - 200));
                pos_y = $signed(24'(pos_y + $signed($urandom_range(0, 400)) - 200));
            end
            if ($urandom_range(0, 19) == 0)
                yaw = 15'($urandom);
            else
                yaw = 15'($urandom_range(0, 23040));
            send_nav(pos_x, pos_y, yaw, 18'($urandom));
        end
    endtask

    initial
    begin
        board = new();
        idle_cycles = 0;
        stall_left = 0;
        pos_x = 0;
        pos_y = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: first sample, extremes, wrap cases
        send_nav(24'sd100, -24'sd100, 15'd0, 18'sd0);
        send_nav(24'sd110, -24'sd95, 15'd5760, 18'sd131071);
        send_nav(24'sd8388607, 24'sh800000, 15'd11520, 18'sh20000);
        send_nav(24'sh800000, 24'sd8388607, 15'd23040, 18'sd1);
        send_nav(-24'sd8388600, 24'sd8388600, 15'd32767, -18'sd1);
        send_nav(24'sd0, 24'sd0, 15'd11521, 18'sd64);
        send_nav(24'sd5, 24'sd3, 15'd17280, 18'sd0);
        drain();
        write_cfg(REG_SAMPLE_RATE, 16'd0);
        write_cfg(REG_NEGATE_RATE, 16'd0);
        send_nav(24'sd50, 24'sd50, 15'd100, 18'sd500);
        send_nav(24'sd90, 24'sd10, 15'd200, -18'sd500);
        drain();
        write_cfg(REG_SAMPLE_RATE, 16'd1000);
        write_cfg(REG_SPEED_LIMIT, 16'd0);
        send_nav(24'sd70, 24'sd20, 15'd300, 18'sd7);
        drain();
        write_cfg(REG_SPEED_LIMIT, 16'd65535);
        write_cfg(REG_YAW_DRIFT, 16'h1FF & 16'(-180));
        send_nav(24'sd170, -24'sd80, 15'd23040, 18'sd9);
        send_nav(24'sd100, 24'sd0, 15'd0, 18'sd9);
        drain();
        write_cfg(REG_YAW_DRIFT, 16'd180);
        send_nav(24'sd80, 24'sd40, 15'd0, 18'sd9);
        send_nav(24'sd30, 24'sd90, 15'd32767, 18'sd9);
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            write_cfg(REG_SAMPLE_RATE, (ph == 0) ? 16'd1 : 16'($urandom_range(1, 1000)));
            write_cfg(REG_SPEED_LIMIT, (ph == 1) ? 16'd65535 : 16'($urandom));
            write_cfg(REG_YAW_DRIFT, 16'h1FF & 16'($urandom_range(0, 360) - 180));
            write_cfg(REG_NEGATE_RATE, 16'(ph & 1));
            random_phase(235);
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: files.f
src/gve_pkg.sv
src/gve_cordic_cell.sv
src/gps_imu_body_velocity_estimator_core.sv
bench/tb_gps_imu_body_velocity_estimator_core.sv
